// ===== hw/rtl/blsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsc_pkg
// Shared types and codes for the bitmap layer scanline compositor.
// ----------------------------------------------------------------------------
package blsc_pkg;

  localparam logic [1:0] REQ_MEM_WRITE  = 2'd0;
  localparam logic [1:0] REQ_DESC_WRITE = 2'd1;
  localparam logic [1:0] REQ_RENDER     = 2'd2;
  localparam logic [1:0] REQ_END_LINE   = 2'd3;

  localparam logic [2:0] SLOT_MODE    = 3'd0;
  localparam logic [2:0] SLOT_W       = 3'd1;
  localparam logic [2:0] SLOT_H       = 3'd2;
  localparam logic [2:0] SLOT_X       = 3'd3;
  localparam logic [2:0] SLOT_Y       = 3'd4;
  localparam logic [2:0] SLOT_TILESET = 3'd5;
  localparam logic [2:0] SLOT_PALETTE = 3'd6;
  localparam logic [2:0] SLOT_DATA    = 3'd7;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [11:0] LINE_MAX = 12'd4095;

  typedef struct packed {
    logic load;       // capture request fields
    logic scan_start; // select first layer
    logic window;     // compute window test for current layer
    logic offset;     // multiply and register offset
    logic rd_index;   // issue index byte read
    logic rd_pal0;    // issue palette reads
    logic rd_pal1;
    logic rd_pal2;
    logic cap0;       // capture palette bytes
    logic cap1;
    logic cap2;
    logic next_layer;
    logic mem_write;
    logic desc_write;
    logic end_line;
    logic finish;     // present result
  } blsc_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       pixel_out;  // pixel beyond line
    logic       hit;        // layer covers pixel
    logic       last_layer;
  } blsc_stat_t;

endpackage

// ===== hw/rtl/blsc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module blsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/blsc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsc_ctrl
// Request sequencer: walks the layers for a pixel and issues memory reads.
// ----------------------------------------------------------------------------
module blsc_ctrl
  import blsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  blsc_stat_t stat,
  output blsc_cmd_t  cmd
);
  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECODE = 11'b00000000010,
    S_WIN    = 11'b00000000100,
    S_OFF    = 11'b00000001000,
    S_IDX    = 11'b00000010000,
    S_IDXW   = 11'b00000100000,
    S_P0     = 11'b00001000000,
    S_P1     = 11'b00010000000,
    S_P2     = 11'b00100000000,
    S_P3     = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.req)
          REQ_MEM_WRITE: begin
            cmd.mem_write = 1'b1;
            state_next = S_DONE;
          end
          REQ_DESC_WRITE: begin
            cmd.desc_write = 1'b1;
            state_next = S_DONE;
          end
          REQ_END_LINE: begin
            cmd.end_line = 1'b1;
            state_next = S_DONE;
          end
          default: begin
            cmd.scan_start = 1'b1;
            state_next = stat.pixel_out ? S_DONE : S_WIN;
          end
        endcase
      end
      S_WIN: begin
        cmd.window = 1'b1;
        state_next = S_OFF;
      end
      S_OFF: begin
        cmd.offset = 1'b1;
        if (stat.hit) begin
          state_next = S_IDX;
        end else if (stat.last_layer) begin
          state_next = S_DONE;
        end else begin
          cmd.next_layer = 1'b1;
          state_next = S_WIN;
        end
      end
      S_IDX: begin
        cmd.rd_index = 1'b1;
        state_next = S_IDXW;
      end
      S_IDXW: begin
        cmd.rd_index = 1'b1;
        state_next = S_P0;
      end
      S_P0: begin
        cmd.rd_pal0 = 1'b1;
        state_next = S_P1;
      end
      S_P1: begin
        cmd.rd_pal1 = 1'b1;
        cmd.cap0 = 1'b1;
        state_next = S_P2;
      end
      S_P2: begin
        cmd.rd_pal2 = 1'b1;
        cmd.cap1 = 1'b1;
        state_next = S_P3;
      end
      S_P3: begin
        cmd.cap2 = 1'b1;
        if (stat.last_layer) begin
          state_next = S_DONE;
        end else begin
          cmd.next_layer = 1'b1;
          state_next = S_WIN;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/blsc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsc_datapath
// Descriptor table, video memory, window test and result registers.
// ----------------------------------------------------------------------------
module blsc_datapath
  import blsc_pkg::*;
#(
  parameter int MEMORY_BYTES = 65536,
  parameter int LAYER_COUNT  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  blsc_cmd_t   cmd,
  output blsc_stat_t  stat,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic [1:0]  req_type,
  input  logic [15:0] mem_address,
  input  logic [7:0]  mem_byte,
  input  logic [2:0]  layer_number,
  input  logic [2:0]  word_slot,
  input  logic [31:0] word_value,
  input  logic [11:0] pixel_x,
  output logic        done,
  output logic [7:0]  first_colour,
  output logic [7:0]  second_colour,
  output logic [7:0]  third_colour,
  output logic [11:0] line_number,
  output logic [3:0]  hblank_count,
  output logic        vblank
);
  localparam int AW = $clog2(MEMORY_BYTES);
  localparam int LW = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int CW = $clog2(LAYER_COUNT + 1);

  logic [12:0] screen_width, screen_height;
  logic [11:0] current_line;

  logic [LAYER_COUNT-1:0] mode_on;
  logic [31:0] lw_q [LAYER_COUNT];
  logic [31:0] lh_q [LAYER_COUNT];
  logic [31:0] lx_q [LAYER_COUNT];
  logic [31:0] ly_q [LAYER_COUNT];
  logic [31:0] pal_q [LAYER_COUNT];
  logic [31:0] dat_q [LAYER_COUNT];

  logic [1:0]  req;
  logic [15:0] maddr;
  logic [7:0]  mbyte;
  logic [2:0]  lnum, slot;
  logic [31:0] wval;
  logic [11:0] px;

  logic [LW-1:0] layer;
  logic          win_ok;
  logic signed [33:0] xx, yy, lw_s;
  logic [31:0] offset;
  logic          hit;
  logic [31:0] pal_base;
  logic [7:0]  c0, c1, c2;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  blsc_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_vmem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 13'd320;
      screen_height <= 13'd240;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) begin
        screen_width <= cfg_data;
      end else begin
        screen_height <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= req_type;
      maddr <= mem_address;
      mbyte <= mem_byte;
      lnum  <= layer_number;
      slot  <= word_slot;
      wval  <= word_value;
      px    <= pixel_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_on <= '0;
      for (int i = 0; i < LAYER_COUNT; i++) begin
        lw_q[i]  <= '0;
        lh_q[i]  <= '0;
        lx_q[i]  <= '0;
        ly_q[i]  <= '0;
        pal_q[i] <= '0;
        dat_q[i] <= '0;
      end
    end else if (cmd.desc_write && (32'(lnum) < 32'(LAYER_COUNT))) begin
      unique case (slot)
        SLOT_MODE:    mode_on[LW'(lnum)] <= (wval != 32'd0);
        SLOT_W:       lw_q[LW'(lnum)]    <= wval;
        SLOT_H:       lh_q[LW'(lnum)]    <= wval;
        SLOT_X:       lx_q[LW'(lnum)]    <= wval;
        SLOT_Y:       ly_q[LW'(lnum)]    <= wval;
        SLOT_PALETTE: pal_q[LW'(lnum)]   <= wval;
        SLOT_DATA:    dat_q[LW'(lnum)]   <= wval;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layer <= '0;
    end else if (cmd.scan_start) begin
      layer <= '0;
    end else if (cmd.next_layer) begin
      layer <= layer + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.window) begin
      xx   <= $signed({22'd0, px}) - $signed({{2{lx_q[layer][31]}}, lx_q[layer]});
      yy   <= $signed({22'd0, current_line}) - $signed({{2{ly_q[layer][31]}}, ly_q[layer]});
      lw_s <= $signed({{2{lw_q[layer][31]}}, lw_q[layer]});
      win_ok <= mode_on[layer];
    end
  end

  logic signed [33:0] lh_s;
  logic               in_win;
  logic [2*AW-1:0]    off_prod;
  logic [2*AW:0]      off_sum;
  logic               off_big;
  assign lh_s = $signed({{2{lh_q[layer][31]}}, lh_q[layer]});
  assign in_win = win_ok && !xx[33] && (xx < lw_s) && !yy[33] && (yy < lh_s);
  // inside the window any upper bit of xx, yy or (for yy > 0) w puts the offset past memory
  assign off_big = (xx[33:AW] != '0) || (yy[33:AW] != '0) ||
                   ((yy != '0) && (lw_s[33:AW] != '0));
  assign off_prod = {{AW{1'b0}}, yy[AW-1:0]} * {{AW{1'b0}}, lw_s[AW-1:0]};
  assign off_sum  = {{(AW+1){1'b0}}, xx[AW-1:0]} + {1'b0, off_prod};
  assign hit = in_win && !off_big && (off_sum < (2*AW+1)'(MEMORY_BYTES));

  always_ff @(posedge clk) begin
    if (cmd.offset) begin
      offset <= 32'(off_sum);
    end
    if (cmd.rd_pal0) begin
      pal_base <= pal_q[layer] + ({24'd0, ram_rdata} * 32'd3);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = mbyte;
    ram_addr  = AW'(maddr);
    if (cmd.mem_write) begin
      ram_we = 1'b1;
    end else if (cmd.rd_index) begin
      ram_addr = AW'(dat_q[layer] + offset);
    end else if (cmd.rd_pal0) begin
      ram_addr = AW'(pal_q[layer] + ({24'd0, ram_rdata} * 32'd3));
    end else if (cmd.rd_pal1) begin
      ram_addr = AW'(pal_base + 32'd1);
    end else if (cmd.rd_pal2) begin
      ram_addr = AW'(pal_base + 32'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c0 <= '0;
      c1 <= '0;
      c2 <= '0;
    end else begin
      if (cmd.cap0) c0 <= ram_rdata;
      if (cmd.cap1) c1 <= ram_rdata;
      if (cmd.cap2) c2 <= ram_rdata;
    end
  end

  logic [CW-1:0] enabled;
  always_comb begin
    enabled = '0;
    for (int i = 0; i < LAYER_COUNT; i++) begin
      enabled = enabled + CW'(mode_on[i]);
    end
  end

  logic [12:0] line_inc;
  logic        wrap;
  assign line_inc = {1'b0, current_line} + 13'd1;
  assign wrap = (line_inc >= screen_height) || (line_inc > {1'b0, LINE_MAX});

  always_ff @(posedge clk) begin
    if (rst) begin
      current_line <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.end_line) begin
        current_line <= wrap ? 12'd0 : line_inc[11:0];
      end
    end
  end

  logic [3:0] hb_q;
  logic       vb_q;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hb_q <= '0;
      vb_q <= 1'b0;
    end else if (cmd.end_line) begin
      hb_q <= 4'(enabled);
      vb_q <= wrap;
    end
    if (cmd.finish) begin
      first_colour  <= c0;
      second_colour <= c1;
      third_colour  <= c2;
      line_number   <= current_line;
      hblank_count  <= hb_q;
      vblank        <= vb_q;
    end
  end

  assign stat.req        = req;
  assign stat.pixel_out  = ({1'b0, px} >= screen_width);
  assign stat.hit        = hit;
  assign stat.last_layer = (32'(layer) == 32'(LAYER_COUNT - 1));
endmodule

// ===== hw/rtl/bitmap_layer_scanline_compositor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_layer_scanline_compositor_top
// Composites up to eight bitmap layers one pixel per request.
// ----------------------------------------------------------------------------
// Channel  | Handshake          | Payload
// request  | start / busy       | req_type, mem_address, mem_byte, layer_number,
//          |                    | word_slot, word_value, pixel_x
// result   | done (one cycle)   | first/second/third_colour, line_number,
//          |                    | hblank_count, vblank
// config   | cfg_we             | cfg_index, cfg_data
// Writes, end line and a pixel beyond the line go from decode to the done state,
// from which done is registered; the receiver cannot stall. A new start is
// taken while done is high. A pixel passes window and offset per layer; a covering
// layer then reads index and three palette bytes over the single memory port.
// Sync reset clears layer table and line and sets sizes 320x240; memory is kept.
// ----------------------------------------------------------------------------
module bitmap_layer_scanline_compositor_top
  import blsc_pkg::*;
#(
  parameter int MEMORY_BYTES = 65536,
  parameter int LAYER_COUNT  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic [1:0]  req_type,
  input  logic [15:0] mem_address,
  input  logic [7:0]  mem_byte,
  input  logic [2:0]  layer_number,
  input  logic [2:0]  word_slot,
  input  logic [31:0] word_value,
  input  logic [11:0] pixel_x,
  output logic        done,
  output logic [7:0]  first_colour,
  output logic [7:0]  second_colour,
  output logic [7:0]  third_colour,
  output logic [11:0] line_number,
  output logic [3:0]  hblank_count,
  output logic        vblank
);
  blsc_cmd_t  cmd;
  blsc_stat_t stat;

  blsc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  blsc_datapath #(
    .MEMORY_BYTES (MEMORY_BYTES),
    .LAYER_COUNT  (LAYER_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .mem_address   (mem_address),
    .mem_byte      (mem_byte),
    .layer_number  (layer_number),
    .word_slot     (word_slot),
    .word_value    (word_value),
    .pixel_x       (pixel_x),
    .done          (done),
    .first_colour  (first_colour),
    .second_colour (second_colour),
    .third_colour  (third_colour),
    .line_number   (line_number),
    .hblank_count  (hblank_count),
    .vblank        (vblank)
  );
endmodule

// ===== hw/rtl/blsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsc_checker
// Port-level checks on the compositor's request and result timing.
// ----------------------------------------------------------------------------
module blsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [11:0] line_number,
  input logic [3:0]  hblank_count,
  input logic        vblank
);
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("transfer not taken");
  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_vb_line: assert property (@(posedge clk) disable iff (rst)
    done && vblank |-> line_number == 12'd0) else $error("vblank off line zero");
  a_hb_max: assert property (@(posedge clk) disable iff (rst)
    done |-> hblank_count <= 4'd8 || !vblank) else $error("hblank count too big");
endmodule

bind bitmap_layer_scanline_compositor_top blsc_checker u_blsc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .line_number  (line_number),
  .hblank_count (hblank_count),
  .vblank       (vblank)
);
